// ===== sv/rrkd_pkg.sv =====
package rrkd_pkg;

   localparam int SLOT_FIELDS = 3;
   localparam int BUTTONS = 13;
   localparam logic [6:0] REPORT_LEN = 7'd9;
   localparam logic [7:0] REPORT_ID = 8'h01;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_PRESSED  = 3'd1,
      KIND_RELEASED = 3'd2,
      KIND_UNKNOWN  = 3'd3,
      KIND_REJECTED = 3'd4
   } kind_type;

   typedef struct packed {
      logic        vld;
      kind_type    kind;
      logic [3:0]  idx;
      logic [15:0] usage;
   } res_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } lookup_type;

   localparam logic [15:0] BUTTON_TABLE [BUTTONS] = '{
      16'h0028, 16'h0035, 16'h004A, 16'h004F, 16'h0050, 16'h0051, 16'h0052,
      16'h0065, 16'h0066, 16'h007F, 16'h0080, 16'h0081, 16'h00F1
   };

   function automatic lookup_type lookup_button(input logic [15:0] usage);
      lookup_type res;
      res = '0;
      for (int i = 0; i < BUTTONS; i++) begin
         if (usage != 16'd0 && BUTTON_TABLE[i] == usage) begin
            res.hit = 1'b1;
            res.idx = 4'(i);
         end
      end
      return res;
   endfunction

endpackage

// ===== sv/remote_report_key_edge_diff.sv =====
// Key edge differ for remote-control reports. Each request is a report or a
// disconnect; it yields one to 2*SLOTS results (pressed, released, unknown,
// or a single no-edge / rejected marker), the final one flagged by
// rsp_last_of_run. Results leave the output buffer one per cycle while
// rsp_ready is high; the next request is taken into the input register
// while the buffer still drains and is evaluated by the lanes in the cycle
// the buffer hands off its last result. The active set is updated when a
// request is evaluated, unless the report is rejected.
module remote_report_key_edge_diff import rrkd_pkg::*; #(
   parameter int SLOTS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [6:0]  req_report_length,
   input  logic [7:0]  req_report_id,
   input  logic [7:0]  req_pad_byte_a,
   input  logic [7:0]  req_pad_byte_b,
   input  logic [15:0] req_usage_slot_0,
   input  logic [15:0] req_usage_slot_1,
   input  logic [15:0] req_usage_slot_2,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_edge_kind,
   output logic [3:0]  rsp_button_index,
   output logic [15:0] rsp_usage_code,
   output logic        rsp_last_of_run
);

   logic        req_vld_ff;
   logic        action_ff;
   logic [6:0]  length_ff;
   logic [7:0]  id_ff;
   logic [7:0]  pad_a_ff;
   logic [7:0]  pad_b_ff;
   logic [15:0] slot_ff [SLOT_FIELDS];
   logic [15:0] active_ff [SLOTS];
   logic [15:0] active_in [SLOTS];
   logic [15:0] fresh [SLOTS];
   res_type     press_res [SLOTS];
   res_type     release_res [SLOTS];
   logic        emit_free;
   logic        load;
   logic        good;
   logic        reject;
   logic        active_empty;
   kind_type    out_kind;

   assign load      = req_vld_ff && emit_free;
   assign req_ready = !req_vld_ff || load;
   assign good      = (length_ff == REPORT_LEN) && (id_ff == REPORT_ID) &&
                      (pad_a_ff == 8'd0) && (pad_b_ff == 8'd0);
   assign reject    = !action_ff && !good;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_ready) begin
         req_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         action_ff  <= req_action;
         length_ff  <= req_report_length;
         id_ff      <= req_report_id;
         pad_a_ff   <= req_pad_byte_a;
         pad_b_ff   <= req_pad_byte_b;
         slot_ff[0] <= req_usage_slot_0;
         slot_ff[1] <= req_usage_slot_1;
         slot_ff[2] <= req_usage_slot_2;
      end
   end

   // disconnect evaluates against an empty new set
   rrkd_sort #(.SLOTS(SLOTS)) u_sort (
      .clear   (action_ff),
      .slot_in (slot_ff),
      .fresh   (fresh)
   );

   for (genvar k = 0; k < SLOTS; k++) begin : g_lane
      rrkd_lane #(.SLOTS(SLOTS)) u_lane (
         .fresh_usage (fresh[k]),
         .old_usage   (active_ff[k]),
         .fresh_set   (fresh),
         .old_set     (active_ff),
         .press_res   (press_res[k]),
         .release_res (release_res[k])
      );
   end

   rrkd_emit #(.SLOTS(SLOTS)) u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .reject      (reject),
      .press_res   (press_res),
      .release_res (release_res),
      .rsp_ready   (rsp_ready),
      .free        (emit_free),
      .rsp_valid   (rsp_valid),
      .rsp_kind    (out_kind),
      .rsp_idx     (rsp_button_index),
      .rsp_usage   (rsp_usage_code),
      .rsp_last    (rsp_last_of_run)
   );

   assign rsp_edge_kind = out_kind;

   // hold the active set on a rejected report
   always_comb begin
      active_empty = 1'b1;
      for (int k = 0; k < SLOTS; k++) begin
         active_in[k] = reject ? active_ff[k] : fresh[k];
         if (active_ff[k] != 16'd0) active_empty = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) active_ff[k] <= '0;
      end else if (load) begin
         active_ff <= active_in;
      end
   end

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      load && reject |=> $stable(active_ff[0]))
      else $error("active set changed on a rejected report");

   a_disconnect_clears: assert property (@(posedge clock) disable iff (reset)
      load && action_ff |=> active_empty)
      else $error("active set not cleared by disconnect");

   a_rejected_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_kind == KIND_REJECTED |-> rsp_last_of_run)
      else $error("rejected marker is not alone in its run");

   a_edge_has_usage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_kind == KIND_PRESSED || out_kind == KIND_RELEASED)
      |-> rsp_usage_code != 16'd0)
      else $error("edge result without usage");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_run && !load |=> !rsp_valid)
      else $error("results continue past end of run");

endmodule

// ===== sv/rrkd_sort.sv =====
module rrkd_sort import rrkd_pkg::*; #(
   parameter int SLOTS = 3
) (
   input  logic        clear,
   input  logic [15:0] slot_in [SLOT_FIELDS],
   output logic [15:0] fresh   [SLOTS]
);

   localparam int USED = (SLOTS < SLOT_FIELDS) ? SLOTS : SLOT_FIELDS;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic          keep [SLOT_FIELDS];
   logic [SW-1:0] rank [SLOT_FIELDS];

   // keep the first copy of each nonzero usage, rank by count of smaller kept usages
   always_comb begin
      for (int i = 0; i < SLOT_FIELDS; i++) begin
         keep[i] = 1'b0;
         rank[i] = '0;
      end
      for (int i = 0; i < USED; i++) begin
         keep[i] = (slot_in[i] != 16'd0);
         for (int j = 0; j < i; j++) begin
            if (slot_in[j] == slot_in[i]) keep[i] = 1'b0;
         end
      end
      for (int i = 0; i < USED; i++) begin
         for (int j = 0; j < USED; j++) begin
            if (keep[j] && slot_in[j] < slot_in[i]) rank[i] = rank[i] + SW'(1);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         fresh[k] = '0;
         for (int i = 0; i < USED; i++) begin
            if (!clear && keep[i] && rank[i] == SW'(k)) fresh[k] = fresh[k] | slot_in[i];
         end
      end
   end

endmodule

// ===== sv/rrkd_lane.sv =====
module rrkd_lane import rrkd_pkg::*; #(
   parameter int SLOTS = 3
) (
   input  logic [15:0] fresh_usage,
   input  logic [15:0] old_usage,
   input  logic [15:0] fresh_set [SLOTS],
   input  logic [15:0] old_set   [SLOTS],
   output res_type     press_res,
   output res_type     release_res
);

   lookup_type fresh_lk;
   lookup_type old_lk;
   logic       fresh_was_active;
   logic       old_still_held;

   always_comb begin
      fresh_lk = lookup_button(fresh_usage);
      old_lk   = lookup_button(old_usage);
      fresh_was_active = 1'b0;
      old_still_held   = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (old_set[i] != 16'd0 && old_set[i] == fresh_usage) fresh_was_active = 1'b1;
         if (fresh_set[i] != 16'd0 && fresh_set[i] == old_usage) old_still_held = 1'b1;
      end
   end

   always_comb begin
      press_res = '{vld: 1'b0, kind: KIND_NONE, idx: 4'd0, usage: fresh_usage};
      if (fresh_usage != 16'd0) begin
         if (!fresh_lk.hit) begin
            press_res.vld  = 1'b1;
            press_res.kind = KIND_UNKNOWN;
         end else if (!fresh_was_active) begin
            press_res.vld  = 1'b1;
            press_res.kind = KIND_PRESSED;
            press_res.idx  = fresh_lk.idx;
         end
      end
   end

   always_comb begin
      release_res = '{vld: 1'b0, kind: KIND_RELEASED, idx: old_lk.idx, usage: old_usage};
      if (old_lk.hit && !old_still_held) release_res.vld = 1'b1;
   end

endmodule

// ===== sv/rrkd_emit.sv =====
module rrkd_emit import rrkd_pkg::*; #(
   parameter int SLOTS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic        reject,
   input  res_type     press_res   [SLOTS],
   input  res_type     release_res [SLOTS],
   input  logic        rsp_ready,
   output logic        free,
   output logic        rsp_valid,
   output kind_type    rsp_kind,
   output logic [3:0]  rsp_idx,
   output logic [15:0] rsp_usage,
   output logic        rsp_last
);

   localparam int NE = 2 * SLOTS;
   localparam int PW = $clog2(NE);

   res_type          ent_in [NE];
   res_type          ent_ff [NE];
   logic [NE-1:0]    mask_in;
   logic [NE-1:0]    mask_ff;
   logic [NE-1:0]    rest;
   logic [PW-1:0]    pick;
   logic             take;

   // merge lane findings: new-set order first, then released in old-set order
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         ent_in[k]         = press_res[k];
         ent_in[SLOTS + k] = release_res[k];
      end
      if (reject) begin
         for (int i = 0; i < NE; i++) ent_in[i].vld = 1'b0;
         ent_in[0] = '{vld: 1'b1, kind: KIND_REJECTED, idx: 4'd0, usage: 16'd0};
      end
      for (int i = 0; i < NE; i++) mask_in[i] = ent_in[i].vld;
      if (mask_in == '0) begin
         ent_in[0]  = '{vld: 1'b1, kind: KIND_NONE, idx: 4'd0, usage: 16'd0};
         mask_in[0] = 1'b1;
      end
   end

   always_comb begin
      pick = '0;
      for (int i = NE - 1; i >= 0; i--) begin
         if (mask_ff[i]) pick = PW'(i);
      end
      rest = mask_ff & ~({{(NE - 1){1'b0}}, 1'b1} << pick);
   end

   assign rsp_valid = |mask_ff;
   assign rsp_last  = (rest == '0);
   assign take      = rsp_valid && rsp_ready;
   assign free      = !rsp_valid || (take && rsp_last);
   assign rsp_kind  = ent_ff[pick].kind;
   assign rsp_idx   = ent_ff[pick].idx;
   assign rsp_usage = ent_ff[pick].usage;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (load) begin
         mask_ff <= mask_in;
      end else if (take) begin
         mask_ff <= rest;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= ent_in;
      end
   end

endmodule
